// ===== rtl/core/pidaw_pkg.sv =====
// ----------------------------------------------------------------------------
// pidaw_pkg
// shared types and constants of the three-axis pid controller
// ----------------------------------------------------------------------------
package pidaw_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int AXES         = 3;
  localparam int AX_W         = 2;
  localparam int GAIN_W       = 16;
  localparam int DT_W         = 16;
  localparam int INT_W        = 32;
  localparam int DRV_W        = 16;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_W        = 64;
  localparam int MASK_W       = 3;
  // multiplier digit count: a 16-bit gain or the time step with a zero sign bit
  localparam int MUL_BW       = 17;
  // derivative magnitude clip, q.0
  localparam int DCLIP_SH     = 40;
  localparam int DERIV_W      = DCLIP_SH + 2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_PHASE_A,
    ST_FIN_A,
    ST_PHASE_B,
    ST_FIN_B,
    ST_DONE
  } state_e;

  typedef enum logic {
    KIND_UPDATE = 1'b0,
    KIND_CLEAR  = 1'b1
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAINS_PITCH  = 3'd0,
    REG_GAINS_ROLL   = 3'd1,
    REG_GAINS_YAW    = 3'd2,
    REG_LIMITS_PITCH = 3'd3,
    REG_LIMITS_ROLL  = 3'd4,
    REG_LIMITS_YAW   = 3'd5
  } reg_idx_e;

  typedef enum logic [AX_W-1:0] {
    AX_PITCH = 2'd0,
    AX_ROLL  = 2'd1,
    AX_YAW   = 2'd2
  } axis_e;

  typedef struct packed {
    logic signed [GAIN_W-1:0] neu;
    logic signed [GAIN_W-1:0] kd;
    logic signed [GAIN_W-1:0] ki;
    logic signed [GAIN_W-1:0] kp;
  } gains_t;

  typedef struct packed {
    logic signed [DRV_W-1:0] imax;
    logic signed [DRV_W-1:0] imin;
    logic signed [DRV_W-1:0] omax;
    logic signed [DRV_W-1:0] omin;
  } limits_t;

endpackage

// ===== rtl/core/pidaw_if.sv =====
// ----------------------------------------------------------------------------
// pidaw channel interfaces
// update request, drive result and configuration write channels
// ----------------------------------------------------------------------------
interface pidaw_upd_if #(
  parameter int SampleWidth = pidaw_pkg::SAMPLE_WIDTH
);
  logic                                valid;
  logic                                ready;
  logic                                kind;
  logic signed [SampleWidth-1:0]       setpoint_pitch;
  logic signed [SampleWidth-1:0]       setpoint_roll;
  logic signed [SampleWidth-1:0]       setpoint_yaw;
  logic signed [SampleWidth-1:0]       measure_pitch;
  logic signed [SampleWidth-1:0]       measure_roll;
  logic signed [SampleWidth-1:0]       measure_yaw;
  logic [pidaw_pkg::DT_W-1:0]          time_step;
  logic [pidaw_pkg::MASK_W-1:0]        clear_mask;

  modport source (output valid, kind, setpoint_pitch, setpoint_roll, setpoint_yaw,
                  measure_pitch, measure_roll, measure_yaw, time_step, clear_mask,
                  input ready);
  modport sink (input valid, kind, setpoint_pitch, setpoint_roll, setpoint_yaw,
                measure_pitch, measure_roll, measure_yaw, time_step, clear_mask,
                output ready);
endinterface

interface pidaw_drv_if;
  logic                                valid;
  logic                                ready;
  logic signed [pidaw_pkg::DRV_W-1:0]  drive_pitch;
  logic signed [pidaw_pkg::DRV_W-1:0]  drive_roll;
  logic signed [pidaw_pkg::DRV_W-1:0]  drive_yaw;

  modport source (output valid, drive_pitch, drive_roll, drive_yaw, input ready);
  modport sink (input valid, drive_pitch, drive_roll, drive_yaw, output ready);
endinterface

interface pidaw_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [pidaw_pkg::CFG_IDX_W-1:0]     index;
  logic [pidaw_pkg::CFG_W-1:0]         data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/three_axis_pid_antiwindup.sv =====
// ----------------------------------------------------------------------------
// three_axis_pid_antiwindup
// three pid axes with clamped integral and conditional integration
// ----------------------------------------------------------------------------
// An update request is worked one axis at a time, pitch, roll then yaw. Each
// axis goes through a setup step, a wait on the bit-serial derivative divider
// (SAMPLE_WIDTH+17 digits; the error times time step product runs beside it),
// a step to clamp the integral, a wait on the bit-serial gain multipliers (17
// digits) and a step to sum, saturate and write back. When no derivative is
// formed (first step after a clear or a zero time step) the divider is not
// started and the first wait is on the error times time step product alone.
// After the last axis the request waits while an earlier result is still held
// in the output register. A clear request gives no result. The finished drives
// wait in an output register, so the next request is taken while the last
// result is still pending. Configuration writes are taken in every cycle.
// ----------------------------------------------------------------------------
module three_axis_pid_antiwindup #(
  parameter int SAMPLE_WIDTH = pidaw_pkg::SAMPLE_WIDTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pidaw_upd_if.sink  upd_i,
  pidaw_drv_if.source drv_o,
  pidaw_cfg_if.sink  cfg_i
);
  import pidaw_pkg::*;

  localparam int SW    = SAMPLE_WIDTH;
  localparam int EW    = SW + 1;
  localparam int DFW   = SW + 2;
  localparam int NW    = SW + 1 + DT_W;
  localparam int QXW   = (NW > DCLIP_SH + 1) ? NW : DCLIP_SH + 1;
  localparam int PEW   = EW + MUL_BW;
  localparam int PIW   = INT_W + MUL_BW;
  localparam int PDW   = DERIV_W + MUL_BW;
  localparam int NIW   = ((INT_W > PEW) ? INT_W : PEW) + 1;
  localparam int SUMW  = ((PDW > PEW) ? PDW : PEW) + 2;
  localparam int UW    = SUMW - 8;

  state_e state_q, state_d;

  // configuration
  logic [CFG_W-1:0] gains_q [AXES];
  logic [CFG_W-1:0] limits_q [AXES];

  // axis state
  logic signed [INT_W-1:0] integral_q [AXES];
  logic signed [EW-1:0]    last_q [AXES];
  logic [AXES-1:0]         have_q;

  // captured request
  logic signed [SW-1:0] sp_q [AXES];
  logic signed [SW-1:0] ms_q [AXES];
  logic [DT_W-1:0]      dt_q;

  // working registers
  logic [AX_W-1:0]         ax_q;
  logic signed [EW-1:0]    e_q;
  logic                    neg_q, use_d_q;
  logic signed [DRV_W-1:0] omin_q, omax_q, imin_q, imax_q, neu_q;
  gains_t                  gq;
  logic signed [INT_W-1:0] ni_q;
  logic signed [DRV_W-1:0] drv_q [AXES];

  // output register
  logic                    out_valid_q;
  logic signed [DRV_W-1:0] out_q [AXES];

  // control
  logic upd_acc, cfg_acc, out_load;
  logic mul_e_start, div_start, prod_start;
  logic mul_e_busy, mul_i_busy, mul_d_busy, div_busy;

  // setup datapath
  gains_t                  g;
  limits_t                 l;
  logic signed [DRV_W-1:0] omin_c, omax_c, imin_c, imax_c, neu_c;
  logic signed [EW-1:0]    e_c;
  logic signed [DFW-1:0]   diff_c, mag_c;
  logic                    use_d_c;
  logic [NW-1:0]           num_c;

  assign g       = gains_t'(gains_q[ax_q]);
  assign l       = limits_t'(limits_q[ax_q]);
  assign omin_c  = (l.omin > l.omax) ? l.omax : l.omin;
  assign omax_c  = (l.omin > l.omax) ? l.omin : l.omax;
  assign imin_c  = (l.imin > l.imax) ? l.imax : l.imin;
  assign imax_c  = (l.imin > l.imax) ? l.imin : l.imax;
  assign neu_c   = (g.neu < omin_c) ? omin_c : ((g.neu > omax_c) ? omax_c : g.neu);
  assign e_c     = {sp_q[ax_q][SW-1], sp_q[ax_q]} - {ms_q[ax_q][SW-1], ms_q[ax_q]};
  assign diff_c  = {e_c[EW-1], e_c} - {last_q[ax_q][EW-1], last_q[ax_q]};
  assign mag_c   = diff_c[DFW-1] ? -diff_c : diff_c;
  assign num_c   = {mag_c[SW:0], {DT_W{1'b0}}};
  assign use_d_c = have_q[ax_q] && (dt_q != '0);

  // serial units
  logic signed [EW-1:0]      mul_e_a;
  logic signed [MUL_BW-1:0]  mul_e_b;
  logic signed [PEW-1:0]     p_e;
  logic signed [PIW-1:0]     p_i;
  logic signed [PDW-1:0]     p_d;
  logic [NW-1:0]             quo;
  logic signed [INT_W-1:0]   ni_c;
  logic signed [DERIV_W-1:0] d_c;

  assign mul_e_a = (state_q == ST_SETUP) ? e_c : e_q;
  assign mul_e_b = (state_q == ST_SETUP) ? {1'b0, dt_q} : {gq.kp[GAIN_W-1], gq.kp};

  pidaw_smul #(.AW(EW)) u_mul_e (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_e_start || prod_start),
    .a_i     (mul_e_a),
    .b_i     (mul_e_b),
    .busy_o  (mul_e_busy),
    .p_o     (p_e)
  );

  pidaw_smul #(.AW(INT_W)) u_mul_i (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (prod_start),
    .a_i     (ni_c),
    .b_i     ({gq.ki[GAIN_W-1], gq.ki}),
    .busy_o  (mul_i_busy),
    .p_o     (p_i)
  );

  pidaw_smul #(.AW(DERIV_W)) u_mul_d (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (prod_start),
    .a_i     (d_c),
    .b_i     ({gq.kd[GAIN_W-1], gq.kd}),
    .busy_o  (mul_d_busy),
    .p_o     (p_d)
  );

  pidaw_sdiv #(.NW(NW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_c),
    .den_i   (dt_q),
    .busy_o  (div_busy),
    .quo_o   (quo)
  );

  // integral clamp and derivative clip
  logic signed [NIW-1:0]   ni_sum, ni_lo, ni_hi;
  logic [QXW-1:0]          q_ext, q_lim;
  logic [DCLIP_SH:0]       dm;

  assign ni_sum = {{(NIW-INT_W){integral_q[ax_q][INT_W-1]}}, integral_q[ax_q]}
                + {{(NIW-PEW){p_e[PEW-1]}}, p_e};
  assign ni_lo  = {{(NIW-DRV_W-DT_W){imin_q[DRV_W-1]}}, imin_q, {DT_W{1'b0}}};
  assign ni_hi  = {{(NIW-DRV_W-DT_W){imax_q[DRV_W-1]}}, imax_q, {DT_W{1'b0}}};

  always_comb begin
    if (dt_q == '0) begin
      ni_c = integral_q[ax_q];
    end else if (ni_sum < ni_lo) begin
      ni_c = ni_lo[INT_W-1:0];
    end else if (ni_sum > ni_hi) begin
      ni_c = ni_hi[INT_W-1:0];
    end else begin
      ni_c = ni_sum[INT_W-1:0];
    end
  end

  assign q_ext = QXW'(quo);
  assign q_lim = QXW'(1) << DCLIP_SH;
  assign dm    = (q_ext > q_lim) ? q_lim[DCLIP_SH:0] : q_ext[DCLIP_SH:0];

  always_comb begin
    if (!use_d_q) begin
      d_c = '0;
    end else if (neg_q) begin
      d_c = -{1'b0, dm};
    end else begin
      d_c = {1'b0, dm};
    end
  end

  // output sum and saturation
  logic signed [SUMW-1:0]  sum_c;
  logic signed [UW-1:0]    u_c, omin_u, omax_u;
  logic signed [DRV_W-1:0] y_c;
  logic                    keep_c;

  assign sum_c = {{(SUMW-DRV_W-8){neu_q[DRV_W-1]}}, neu_q, 8'h00}
               + {{(SUMW-PEW){p_e[PEW-1]}}, p_e}
               + {{(SUMW-PIW+DT_W){p_i[PIW-1]}}, p_i[PIW-1:DT_W]}
               + {{(SUMW-PDW){p_d[PDW-1]}}, p_d}
               + SUMW'(128);
  assign u_c    = sum_c[SUMW-1:8];
  assign omin_u = {{(UW-DRV_W){omin_q[DRV_W-1]}}, omin_q};
  assign omax_u = {{(UW-DRV_W){omax_q[DRV_W-1]}}, omax_q};

  always_comb begin
    if (u_c > omax_u) begin
      y_c    = omax_q;
      keep_c = e_q[EW-1];
    end else if (u_c < omin_u) begin
      y_c    = omin_q;
      keep_c = !e_q[EW-1] && (e_q != '0);
    end else begin
      y_c    = u_c[DRV_W-1:0];
      keep_c = 1'b1;
    end
  end

  // control
  assign upd_acc = upd_i.valid && upd_i.ready;
  assign cfg_acc = cfg_i.valid && cfg_i.ready;
  assign cfg_i.ready = 1'b1;

  always_comb begin
    state_d     = state_q;
    upd_i.ready = 1'b0;
    mul_e_start = 1'b0;
    div_start   = 1'b0;
    prod_start  = 1'b0;
    out_load    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        upd_i.ready = 1'b1;
        if (upd_i.valid && (kind_e'(upd_i.kind) == KIND_UPDATE)) begin
          state_d = ST_SETUP;
        end
      end
      ST_SETUP: begin
        mul_e_start = 1'b1;
        div_start   = use_d_c;
        state_d     = ST_PHASE_A;
      end
      ST_PHASE_A: begin
        if (!mul_e_busy && !div_busy) begin
          state_d = ST_FIN_A;
        end
      end
      ST_FIN_A: begin
        prod_start = 1'b1;
        state_d    = ST_PHASE_B;
      end
      ST_PHASE_B: begin
        if (!mul_e_busy && !mul_i_busy && !mul_d_busy) begin
          state_d = ST_FIN_B;
        end
      end
      ST_FIN_B: begin
        state_d = (ax_q == AX_YAW) ? ST_DONE : ST_SETUP;
      end
      ST_DONE: begin
        if (!out_valid_q || drv_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < AXES; i++) begin
        gains_q[i]  <= '0;
        limits_q[i] <= '0;
      end
    end else if (cfg_acc) begin
      case (reg_idx_e'(cfg_i.index))
        REG_GAINS_PITCH:  gains_q[AX_PITCH]  <= cfg_i.data;
        REG_GAINS_ROLL:   gains_q[AX_ROLL]   <= cfg_i.data;
        REG_GAINS_YAW:    gains_q[AX_YAW]    <= cfg_i.data;
        REG_LIMITS_PITCH: limits_q[AX_PITCH] <= cfg_i.data;
        REG_LIMITS_ROLL:  limits_q[AX_ROLL]  <= cfg_i.data;
        REG_LIMITS_YAW:   limits_q[AX_YAW]   <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // axis state and sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < AXES; i++) begin
        integral_q[i] <= '0;
        last_q[i]     <= '0;
      end
      have_q      <= '0;
      ax_q        <= AX_PITCH;
      out_valid_q <= 1'b0;
    end else begin
      if (upd_acc) begin
        ax_q <= AX_PITCH;
        if (kind_e'(upd_i.kind) == KIND_CLEAR) begin
          for (int i = 0; i < AXES; i++) begin
            if (upd_i.clear_mask[i]) begin
              integral_q[i] <= '0;
              last_q[i]     <= '0;
              have_q[i]     <= 1'b0;
            end
          end
        end
      end
      if (state_q == ST_FIN_B) begin
        if (keep_c) begin
          integral_q[ax_q] <= ni_q;
        end
        last_q[ax_q] <= e_q;
        have_q[ax_q] <= 1'b1;
        ax_q         <= ax_q + 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (drv_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (upd_acc) begin
      sp_q[AX_PITCH] <= upd_i.setpoint_pitch;
      sp_q[AX_ROLL]  <= upd_i.setpoint_roll;
      sp_q[AX_YAW]   <= upd_i.setpoint_yaw;
      ms_q[AX_PITCH] <= upd_i.measure_pitch;
      ms_q[AX_ROLL]  <= upd_i.measure_roll;
      ms_q[AX_YAW]   <= upd_i.measure_yaw;
      dt_q           <= upd_i.time_step;
    end
    if (state_q == ST_SETUP) begin
      e_q     <= e_c;
      neg_q   <= diff_c[DFW-1];
      use_d_q <= use_d_c;
      omin_q  <= omin_c;
      omax_q  <= omax_c;
      imin_q  <= imin_c;
      imax_q  <= imax_c;
      neu_q   <= neu_c;
      gq      <= g;
    end
    if (state_q == ST_FIN_A) begin
      ni_q <= ni_c;
    end
    if (state_q == ST_FIN_B) begin
      drv_q[ax_q] <= y_c;
    end
    if (out_load) begin
      for (int i = 0; i < AXES; i++) begin
        out_q[i] <= drv_q[i];
      end
    end
  end

  assign drv_o.valid       = out_valid_q;
  assign drv_o.drive_pitch = out_q[AX_PITCH];
  assign drv_o.drive_roll  = out_q[AX_ROLL];
  assign drv_o.drive_yaw   = out_q[AX_YAW];

  a_yaw_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN_B) && (ax_q == AX_YAW) |=> state_q == ST_DONE)
    else $error("last axis did not finish the request");
  a_div_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PHASE_B) |-> !div_busy)
    else $error("divider still busy during gain products");
  a_have_set : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN_B) |=> have_q[$past(ax_q)])
    else $error("axis history flag not set");
  a_int_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN_A) && (dt_q != '0) |=>
      ($signed(ni_q) >= $signed({imin_q, 16'h0000}))
      && ($signed(ni_q) <= $signed({imax_q, 16'h0000})))
    else $error("integral outside its limits");

endmodule

// ===== rtl/core/pidaw_smul.sv =====
// ----------------------------------------------------------------------------
// pidaw_smul
// bit-serial signed multiplier, one multiplier bit per cycle
// ----------------------------------------------------------------------------
module pidaw_smul #(
  parameter int AW = 17
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  input  logic signed [AW-1:0]                   a_i,
  input  logic signed [pidaw_pkg::MUL_BW-1:0]    b_i,
  output logic                                   busy_o,
  output logic signed [AW+pidaw_pkg::MUL_BW-1:0] p_o
);
  import pidaw_pkg::*;

  localparam int PW = AW + MUL_BW;
  localparam int CW = $clog2(MUL_BW + 1);

  logic signed [PW-1:0] a_q, acc_q, acc_d, addend;
  logic [MUL_BW-1:0]    b_q;
  logic [CW-1:0]        cnt_q;
  logic                 busy_q;
  logic                 last;

  assign addend = b_q[0] ? a_q : '0;
  assign last   = (cnt_q == CW'(MUL_BW - 1));
  // sign bit of the multiplier carries negative weight
  assign acc_d  = last ? (acc_q - addend) : (acc_q + addend);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (last) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= {{MUL_BW{a_i[AW-1]}}, a_i};
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_d;
      a_q   <= a_q <<< 1;
      b_q   <= b_q >> 1;
    end
  end

  assign busy_o = busy_q;
  assign p_o    = acc_q;

  a_start_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_q && (cnt_q == '0))
    else $error("multiplier did not start");
  a_keep_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !last && !start_i |=> busy_q)
    else $error("multiplier stopped early");
  a_stop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && last && !start_i |=> !busy_q)
    else $error("multiplier overran");

endmodule

// ===== rtl/core/pidaw_sdiv.sv =====
// ----------------------------------------------------------------------------
// pidaw_sdiv
// bit-serial restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module pidaw_sdiv #(
  parameter int NW = 33
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [NW-1:0]                num_i,
  input  logic [pidaw_pkg::DT_W-1:0]   den_i,
  output logic                         busy_o,
  output logic [NW-1:0]                quo_o
);
  import pidaw_pkg::*;

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0]   q_q;
  logic [DT_W-1:0] rem_q, den_q;
  logic [DT_W:0]   trial, diff;
  logic            ge;
  logic [CW-1:0]   cnt_q;
  logic            busy_q;
  logic            last;

  assign trial = {rem_q, q_q[NW-1]};
  assign ge    = (trial >= {1'b0, den_q});
  assign diff  = trial - {1'b0, den_q};
  assign last  = (cnt_q == CW'(NW - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (last) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q   <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      q_q   <= {q_q[NW-2:0], ge};
      rem_q <= ge ? diff[DT_W-1:0] : trial[DT_W-1:0];
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = q_q;

  a_rem_below : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && (den_q != '0) |-> rem_q < den_q)
    else $error("partial remainder not below divisor");
  a_start_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_q && (cnt_q == '0))
    else $error("divider did not start");
  a_stop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && last && !start_i |=> !busy_q)
    else $error("divider overran");

endmodule
